// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer: item structs,
// parse phases, opcodes, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_CAPACITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_PAYLOAD = 4'd1;
  localparam logic [15:0] CAPACITY_RESET = 16'd2048;
  localparam logic DELIVER_RESET = 1'b1;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;

  // header decoding
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] MASK_BIT = 8'h80;
  localparam logic [7:0] LEN_MASK = 8'h7F;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] OP_TEXT = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_PING = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DELIVERED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [6:0] {
    PH_B0      = 7'b0000001,
    PH_B1      = 7'b0000010,
    PH_EXT_HI  = 7'b0000100,
    PH_EXT_LO  = 7'b0001000,
    PH_KEY     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [1:0]  status_code;
    logic [15:0] frame_length;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] receive_capacity;
    logic        deliver_payload;
  } cfg_t;

  // results caused by one accepted byte; the byte result goes first
  typedef struct packed {
    logic emit_byte;
    logic emit_status;
    out_t byte_res;
    out_t status_res;
  } push_t;

endpackage

// ===== sv/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decoder and payload unmasker. Holds the parse state and the
// configuration registers, and turns each accepted byte into up to two results.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_t                  in_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output push_t                push
);

  cfg_t        cfg;
  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_present, mask_present_next;
  logic [15:0] declared_length, declared_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] payload_count, payload_count_next;
  logic        frame_invalid, frame_invalid_next;

  logic [7:0]  b;
  logic [7:0]  key_byte;
  logic        data_op;
  logic        header_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.receive_capacity <= CAPACITY_RESET;
      cfg.deliver_payload <= DELIVER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RECEIVE_CAPACITY: cfg.receive_capacity <= cfg_data;
        CFG_DELIVER_PAYLOAD:  cfg.deliver_payload <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    b = in_data.rx_byte;
    phase_next = phase;
    opcode_next = opcode;
    mask_present_next = mask_present;
    declared_length_next = declared_length;
    mask_key_next = mask_key;
    payload_count_next = payload_count;
    frame_invalid_next = frame_invalid;
    push = '0;

    case (phase)
      PH_B0: begin
        opcode_next = 4'(b & OPCODE_MASK);
        phase_next = PH_B1;
      end
      PH_B1: begin
        mask_present_next = |(b & MASK_BIT);
        if (7'(b & LEN_MASK) == LEN_CODE_64) begin
          frame_invalid_next = 1'b1;
          declared_length_next = '0;
          phase_next = PH_DONE;
        end else if (7'(b & LEN_MASK) == LEN_CODE_16) begin
          phase_next = PH_EXT_HI;
        end else begin
          declared_length_next = {9'd0, b[6:0]};
          payload_count_next = '0;
          if (mask_present_next) phase_next = PH_KEY;
          else if (declared_length_next != '0) phase_next = PH_PAYLOAD;
          else phase_next = PH_DONE;
        end
      end
      PH_EXT_HI: begin
        declared_length_next = {b, 8'h00};
        phase_next = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        declared_length_next = {declared_length[15:8], b};
        payload_count_next = '0;
        if (mask_present) phase_next = PH_KEY;
        else if (declared_length_next != '0) phase_next = PH_PAYLOAD;
        else phase_next = PH_DONE;
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], b};
        if (payload_count[1:0] == 2'd3) begin
          payload_count_next = '0;
          phase_next = (declared_length != '0) ? PH_PAYLOAD : PH_DONE;
        end else begin
          payload_count_next = payload_count + 16'd1;
        end
      end
      PH_PAYLOAD: begin
        data_op = (opcode == OP_TEXT) || (opcode == OP_BINARY);
        push.emit_byte = (opcode == OP_PING) ||
                         (data_op && cfg.deliver_payload &&
                          (declared_length <= cfg.receive_capacity));
        push.byte_res.result_kind = KIND_BYTE;
        push.byte_res.payload_byte = b ^ key_byte;
        push.byte_res.frame_opcode = opcode;
        push.byte_res.status_code = ST_OK;
        push.byte_res.frame_length = declared_length;
        push.byte_res.last = 1'b0;
        // count never reaches the top: it stays below a nonzero 16-bit length
        payload_count_next = payload_count + 16'd1;
        if (payload_count_next >= declared_length) phase_next = PH_DONE;
      end
      default: ;
    endcase

    data_op = (opcode_next == OP_TEXT) || (opcode_next == OP_BINARY);
    header_open = (phase_next == PH_B0) || (phase_next == PH_B1) ||
                  (phase_next == PH_EXT_HI) || (phase_next == PH_EXT_LO) ||
                  (phase_next == PH_KEY);

    push.status_res.result_kind = KIND_STATUS;
    push.status_res.payload_byte = '0;
    push.status_res.frame_opcode = opcode_next;
    push.status_res.last = 1'b1;
    push.status_res.frame_length = declared_length_next;
    push.status_res.status_code = ST_OK;
    if (frame_invalid_next || header_open) begin
      push.status_res.status_code = ST_INVALID;
      push.status_res.frame_length = '0;
    end else if (phase_next == PH_PAYLOAD) begin
      push.status_res.status_code = ST_INVALID;
    end else if (data_op && cfg.deliver_payload) begin
      push.status_res.status_code =
        (declared_length_next > cfg.receive_capacity) ? ST_TOO_SMALL : ST_DELIVERED;
    end

    push.emit_status = in_data.chunk_end;
    push.emit_byte = push.emit_byte & accept;
    push.emit_status = push.emit_status & accept;

    // chunk closed: start over on the next frame
    if (in_data.chunk_end) begin
      phase_next = PH_B0;
      opcode_next = '0;
      mask_present_next = 1'b0;
      declared_length_next = '0;
      mask_key_next = '0;
      payload_count_next = '0;
      frame_invalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_B0;
      opcode <= '0;
      mask_present <= 1'b0;
      declared_length <= '0;
      mask_key <= '0;
      payload_count <= '0;
      frame_invalid <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      opcode <= opcode_next;
      mask_present <= mask_present_next;
      declared_length <= declared_length_next;
      mask_key <= mask_key_next;
      payload_count <= payload_count_next;
      frame_invalid <= frame_invalid_next;
    end
  end

endmodule

// ===== sv/wsd_result_queue.sv =====
// ----------------------------------------------------------------------------
// wsd_result_queue
// Small result queue between parser and output channel. Takes up to two
// results per cycle, hands out one per transfer from a register array.
// ----------------------------------------------------------------------------
module wsd_result_queue
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  out_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign level = count;
  // leave space for the two results a chunk's final byte can cause
  assign room = (count <= CNT_W'(DEPTH-2));
  assign wr_ptr_next = push.emit_byte ? bump(wr_ptr) : wr_ptr;

  always_ff @(posedge clk) begin
    if (push.emit_byte) mem[wr_ptr] <= push.byte_res;
    if (push.emit_status) mem[wr_ptr_next] <= push.status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= push.emit_status ? bump(wr_ptr_next) : wr_ptr_next;
      if (pop) rd_ptr <= bump(rd_ptr);
      count <= count + CNT_W'(push.emit_byte) + CNT_W'(push.emit_status)
                     - CNT_W'(pop);
    end
  end

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side frame parser: one frame per chunk, header decode, payload
// unmasking and a status result at the end of every chunk.
// ----------------------------------------------------------------------------
// A result is written into the queue's register array when its byte is transferred.
// Throughput: one byte per cycle while the queue has room; a final byte that also
//   yields a payload byte puts two results in the queue, handed out one per transfer.
// The queue depth (QUEUE_DEPTH) sets how much output stall is absorbed.
// Reset: parser waits for a first header byte, queue empties, capacity 2048,
//   delivery enabled.
module websocket_frame_deframer_top
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  push_t push;
  logic  accept;
  logic  room;
  logic [$clog2(DEPTH+1)-1:0] level;

  assign cfg_ready = 1'b1;
  assign in_ready = room;
  assign accept = in_valid && in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  wsd_result_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (level)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("result queue overflow");

  a_end_gives_status: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.chunk_end |=> out_valid)
    else $error("chunk end without pending result");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_STATUS |->
      out_data.last && out_data.payload_byte == 8'd0)
    else $error("malformed status result");

  a_byte_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_BYTE |->
      !out_data.last && out_data.status_code == ST_OK)
    else $error("malformed payload byte result");

endmodule
